// ----- hw/rtl/ebd_pkg.sv -----
// Shared types, constants and register codes of the emergency brake decision block.
package ebd_pkg;

  localparam int unsigned POS_WIDTH_DEF = 20;
  localparam int unsigned VEL_WIDTH_DEF = 18;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DECEL_W    = 16;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned OUT_DATA_W = ((DECEL_W + LEVEL_W + 7) / 8) * 8;
  localparam int unsigned LEVEL_LSB  = DECEL_W;
  localparam int unsigned LEVEL_MSB  = DECEL_W + LEVEL_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET     = 3'd0,
    CFG_FB_TTC     = 3'd1,
    CFG_PB_TTC     = 3'd2,
    CFG_HALF_WIDTH = 3'd3,
    CFG_FB_DECEL   = 3'd4,
    CFG_PB_DECEL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NONE = 2'd0,
    LVL_PRE  = 2'd1,
    LVL_FULL = 2'd2
  } brake_level_e;

  typedef struct packed {
    logic        [CFG_W-1:0] offset;
    logic        [CFG_W-1:0] fb_ttc;
    logic        [CFG_W-1:0] pb_ttc;
    logic        [CFG_W-1:0] half_width;
    logic signed [CFG_W-1:0] fb_decel;
    logic signed [CFG_W-1:0] pb_decel;
  } ebd_cfg_t;

  localparam ebd_cfg_t CFG_RESET = '{
    offset:     16'd0,
    fb_ttc:     16'd1000,
    pb_ttc:     16'd2000,
    half_width: 16'd1500,
    fb_decel:   -16'sd10000,
    pb_decel:   -16'sd4000
  };

endpackage

// ----- hw/rtl/ebd_square.sv -----
// Front end: magnitudes, squares and sums of squares for position and velocity.
module ebd_square #(
  parameter int unsigned POS_WIDTH = ebd_pkg::POS_WIDTH_DEF,
  parameter int unsigned VEL_WIDTH = ebd_pkg::VEL_WIDTH_DEF,
  localparam int unsigned SW = (POS_WIDTH > VEL_WIDTH) ? POS_WIDTH : VEL_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic signed [VEL_WIDTH-1:0] vel_x_i,
  input  logic signed [VEL_WIDTH-1:0] vel_y_i,
  input  logic signed [VEL_WIDTH-1:0] vel_z_i,
  input  logic [ebd_pkg::CFG_W-1:0]   half_width_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [2*SW-1:0]             rad_pos_o,
  output logic [2*SW-1:0]             rad_vel_o,
  output logic                        armed_o
);
  import ebd_pkg::*;

  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned VW = VEL_WIDTH;
  localparam int unsigned HW = (PW > CFG_W) ? PW : CFG_W;

  logic vld1_q, vld2_q, vld3_q;
  logic en1, en2, en3;

  // stage 1: magnitudes
  logic [PW-1:0] mpx_d, mpy_d, mpz_d, mpx_q, mpy_q, mpz_q;
  logic [VW-1:0] mvx_d, mvy_d, mvz_d, mvx_q, mvy_q, mvz_q;
  logic          closing_q;
  // stage 2: squares
  logic [2*PW-1:0] spx_q, spy_q, spz_q;
  logic [2*VW-1:0] svx_q, svy_q, svz_q;
  logic            armed2_q;
  // stage 3: sums (three squares of magnitudes up to 2^(W-1) stay below 2^(2W))
  logic [2*PW-1:0] sum_pos_q;
  logic [2*VW-1:0] sum_vel_q;
  logic            armed3_q;

  assign en3     = !vld3_q || ready_i;
  assign en2     = !vld2_q || en3;
  assign en1     = !vld1_q || en2;
  assign ready_o = en1;

  always_comb begin
    mpx_d = pos_x_i[PW-1] ? PW'(-pos_x_i) : PW'(pos_x_i);
    mpy_d = pos_y_i[PW-1] ? PW'(-pos_y_i) : PW'(pos_y_i);
    mpz_d = pos_z_i[PW-1] ? PW'(-pos_z_i) : PW'(pos_z_i);
    mvx_d = vel_x_i[VW-1] ? VW'(-vel_x_i) : VW'(vel_x_i);
    mvy_d = vel_y_i[VW-1] ? VW'(-vel_y_i) : VW'(vel_y_i);
    mvz_d = vel_z_i[VW-1] ? VW'(-vel_z_i) : VW'(vel_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= valid_i;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mpx_q     <= mpx_d;
      mpy_q     <= mpy_d;
      mpz_q     <= mpz_d;
      mvx_q     <= mvx_d;
      mvy_q     <= mvy_d;
      mvz_q     <= mvz_d;
      closing_q <= vel_x_i[VW-1];
    end
    if (en2) begin
      spx_q    <= (2*PW)'(mpx_q) * (2*PW)'(mpx_q);
      spy_q    <= (2*PW)'(mpy_q) * (2*PW)'(mpy_q);
      spz_q    <= (2*PW)'(mpz_q) * (2*PW)'(mpz_q);
      svx_q    <= (2*VW)'(mvx_q) * (2*VW)'(mvx_q);
      svy_q    <= (2*VW)'(mvy_q) * (2*VW)'(mvy_q);
      svz_q    <= (2*VW)'(mvz_q) * (2*VW)'(mvz_q);
      armed2_q <= closing_q && (HW'(mpy_q) < HW'(half_width_i));
    end
    if (en3) begin
      sum_pos_q <= spx_q + spy_q + spz_q;
      sum_vel_q <= svx_q + svy_q + svz_q;
      armed3_q  <= armed2_q;
    end
  end

  assign valid_o   = vld3_q;
  assign rad_pos_o = (2*SW)'(sum_pos_q);
  assign rad_vel_o = (2*SW)'(sum_vel_q);
  assign armed_o   = armed3_q;

endmodule

// ----- hw/rtl/ebd_isqrt.sv -----
// Dual-lane pipelined integer square root, one root bit per stage, MSB first.
module ebd_isqrt #(
  parameter int unsigned ROOT_W = ebd_pkg::POS_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [2*ROOT_W-1:0] rad_a_i,
  input  logic [2*ROOT_W-1:0] rad_b_i,
  input  logic                side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [ROOT_W-1:0]   root_a_o,
  output logic [ROOT_W-1:0]   root_b_o,
  output logic                side_o
);
  import ebd_pkg::*;

  localparam int unsigned NW = 2 * ROOT_W;
  localparam int unsigned TW = NW + 1;

  // stage inputs
  wire [NW-1:0]     rem_w  [ROOT_W][2];
  wire [ROOT_W-1:0] root_w [ROOT_W][2];
  wire [ROOT_W-1:0] vld_w;
  wire [ROOT_W-1:0] side_w;
  wire [ROOT_W:0]   en_w;

  // stage outputs; the last stage keeps no remainder
  logic [NW-1:0]     rem_q  [ROOT_W-1][2];
  logic [ROOT_W-1:0] root_q [ROOT_W][2];
  logic [ROOT_W-1:0] vld_q;
  logic [ROOT_W-1:0] side_q;

  assign en_w[ROOT_W] = ready_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;

    if (k == 0) begin : g_first
      assign rem_w[0][0]  = rad_a_i;
      assign rem_w[0][1]  = rad_b_i;
      assign root_w[0][0] = '0;
      assign root_w[0][1] = '0;
      assign vld_w[0]     = valid_i;
      assign side_w[0]    = side_i;
    end else begin : g_next
      assign rem_w[k][0]  = rem_q[k-1][0];
      assign rem_w[k][1]  = rem_q[k-1][1];
      assign root_w[k][0] = root_q[k-1][0];
      assign root_w[k][1] = root_q[k-1][1];
      assign vld_w[k]     = vld_q[k-1];
      assign side_w[k]    = side_q[k-1];
    end

    assign en_w[k] = !vld_q[k] || en_w[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_w[k]) begin
        vld_q[k] <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_w[k]) side_q[k] <= side_w[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [TW-1:0]     trial;
      logic              take;
      logic [NW-1:0]     rem_d;
      logic [ROOT_W-1:0] root_d;

      // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
      always_comb begin
        trial  = (TW'(root_w[k][l]) << (B + 1)) | (TW'(1) << (2 * B));
        take   = TW'(rem_w[k][l]) >= trial;
        rem_d  = take ? rem_w[k][l] - NW'(trial) : rem_w[k][l];
        root_d = take ? (root_w[k][l] | (ROOT_W'(1) << B)) : root_w[k][l];
      end

      always_ff @(posedge clk_i) begin
        if (en_w[k]) root_q[k][l] <= root_d;
      end

      if (k < ROOT_W - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_w[k]) rem_q[k][l] <= rem_d;
        end
      end
    end
  end

  assign ready_o  = en_w[0];
  assign valid_o  = vld_q[ROOT_W-1];
  assign root_a_o = root_q[ROOT_W-1][0];
  assign root_b_o = root_q[ROOT_W-1][1];
  assign side_o   = side_q[ROOT_W-1];

endmodule

// ----- hw/rtl/ebd_decide.sv -----
// Back end: distance, cross-multiplied TTC compares and brake selection.
module ebd_decide #(
  parameter int unsigned ROOT_W = ebd_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ebd_pkg::ebd_cfg_t            cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [ROOT_W-1:0]            range_i,
  input  logic [ROOT_W-1:0]            speed_i,
  input  logic                         armed_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [ebd_pkg::DECEL_W-1:0] decel_o,
  output ebd_pkg::brake_level_e        level_o
);
  import ebd_pkg::*;

  localparam int unsigned DW  = ((ROOT_W > CFG_W) ? ROOT_W : CFG_W) + 1;
  localparam int unsigned LW  = DW + 10;
  localparam int unsigned PRW = CFG_W + ROOT_W;
  localparam int unsigned CW  = ((LW > PRW) ? LW : PRW) + 1;

  logic vld_a_q, vld_b_q, vld_c_q;
  logic en_a, en_b, en_c;

  logic signed [DW-1:0] dist_d, dist_q;
  logic [PRW-1:0]       pfb_a_q, ppb_a_q, pfb_b_q, ppb_b_q;
  logic                 armed_a_q, armed_b_q;
  logic signed [LW-1:0] dist_ext, lhs_d, lhs_q;
  logic signed [CW-1:0] lhs_c, pfb_c, ppb_c;
  logic                 full, pre;
  logic signed [DECEL_W-1:0] decel_d, decel_q;
  brake_level_e         level_d, level_q;

  assign en_c    = !vld_c_q || ready_i;
  assign en_b    = !vld_b_q || en_c;
  assign en_a    = !vld_a_q || en_b;
  assign ready_o = en_a;

  // range minus offset may go negative
  assign dist_d   = DW'(range_i) - DW'(cfg_i.offset);
  // x1000 = x1024 - x32 + x8
  assign dist_ext = LW'(dist_q);
  assign lhs_d    = (dist_ext <<< 10) - (dist_ext <<< 5) + (dist_ext <<< 3);

  always_comb begin
    lhs_c = CW'(lhs_q);
    pfb_c = CW'(pfb_b_q);
    ppb_c = CW'(ppb_b_q);
    full  = lhs_c < pfb_c;
    pre   = lhs_c < ppb_c;
    decel_d = '0;
    level_d = LVL_NONE;
    if (armed_b_q && full) begin
      decel_d = cfg_i.fb_decel;
      level_d = LVL_FULL;
    end else if (armed_b_q && pre) begin
      decel_d = cfg_i.pb_decel;
      level_d = LVL_PRE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (en_a) vld_a_q <= valid_i;
      if (en_b) vld_b_q <= vld_a_q;
      if (en_c) vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      dist_q    <= dist_d;
      pfb_a_q   <= PRW'(cfg_i.fb_ttc) * PRW'(speed_i);
      ppb_a_q   <= PRW'(cfg_i.pb_ttc) * PRW'(speed_i);
      armed_a_q <= armed_i;
    end
    if (en_b) begin
      lhs_q     <= lhs_d;
      pfb_b_q   <= pfb_a_q;
      ppb_b_q   <= ppb_a_q;
      armed_b_q <= armed_a_q;
    end
    if (en_c) begin
      decel_q <= decel_d;
      level_q <= level_d;
    end
  end

  assign valid_o = vld_c_q;
  assign decel_o = decel_q;
  assign level_o = level_q;

endmodule

// ----- hw/rtl/ttc_emergency_brake_decision_top.sv -----
// Pipeline stages: POS_WIDTH/VEL_WIDTH-dependent:
//   three front-end stages, one square-root stage per root bit, three decision stages.
// Throughput: one word per cycle while m_axis_tready is high; every stage moves on when its successor is free,
//   so bubbles close up while the output word waits.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
module ttc_emergency_brake_decision_top #(
  parameter int unsigned POS_WIDTH = ebd_pkg::POS_WIDTH_DEF,
  parameter int unsigned VEL_WIDTH = ebd_pkg::VEL_WIDTH_DEF,
  localparam int unsigned IN_DATA_W = ((3 * POS_WIDTH + 3 * VEL_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
  input  logic [IN_DATA_W-1:0]            s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // decel_request, brake_level, zero pad
  output logic [ebd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [ebd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ebd_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import ebd_pkg::*;

  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned VW = VEL_WIDTH;
  localparam int unsigned SW = (PW > VW) ? PW : VW;

  ebd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET:     cfg_q.offset     <= cfg_wdata_i;
        CFG_FB_TTC:     cfg_q.fb_ttc     <= cfg_wdata_i;
        CFG_PB_TTC:     cfg_q.pb_ttc     <= cfg_wdata_i;
        CFG_HALF_WIDTH: cfg_q.half_width <= cfg_wdata_i;
        CFG_FB_DECEL:   cfg_q.fb_decel   <= cfg_wdata_i;
        CFG_PB_DECEL:   cfg_q.pb_decel   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic signed [VW-1:0] vel_x, vel_y, vel_z;

  assign pos_x = s_axis_tdata[PW-1:0];
  assign pos_y = s_axis_tdata[2*PW-1:PW];
  assign pos_z = s_axis_tdata[3*PW-1:2*PW];
  assign vel_x = s_axis_tdata[3*PW+VW-1:3*PW];
  assign vel_y = s_axis_tdata[3*PW+2*VW-1:3*PW+VW];
  assign vel_z = s_axis_tdata[3*PW+3*VW-1:3*PW+2*VW];

  logic            sq_valid, sq_ready, sq_armed;
  logic [2*SW-1:0] sq_rad_pos, sq_rad_vel;
  logic            rt_valid, rt_ready, rt_armed;
  logic [SW-1:0]   rt_range, rt_speed;
  logic signed [DECEL_W-1:0] decel;
  brake_level_e    level;

  ebd_square #(
    .POS_WIDTH (PW),
    .VEL_WIDTH (VW)
  ) u_square (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .vel_x_i      (vel_x),
    .vel_y_i      (vel_y),
    .vel_z_i      (vel_z),
    .half_width_i (cfg_q.half_width),
    .valid_o      (sq_valid),
    .ready_i      (sq_ready),
    .rad_pos_o    (sq_rad_pos),
    .rad_vel_o    (sq_rad_vel),
    .armed_o      (sq_armed)
  );

  ebd_isqrt #(
    .ROOT_W (SW)
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_valid),
    .ready_o  (sq_ready),
    .rad_a_i  (sq_rad_pos),
    .rad_b_i  (sq_rad_vel),
    .side_i   (sq_armed),
    .valid_o  (rt_valid),
    .ready_i  (rt_ready),
    .root_a_o (rt_range),
    .root_b_o (rt_speed),
    .side_o   (rt_armed)
  );

  ebd_decide #(
    .ROOT_W (SW)
  ) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rt_valid),
    .ready_o (rt_ready),
    .range_i (rt_range),
    .speed_i (rt_speed),
    .armed_i (rt_armed),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .decel_o (decel),
    .level_o (level)
  );

  assign m_axis_tdata = {(OUT_DATA_W - DECEL_W - LEVEL_W)'(0), level, decel};

endmodule

// ----- hw/rtl/ebd_checker.sv -----
// Port-level checks on the brake decision block, bound to its top level.
module ebd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ebd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ebd_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // no brake level means no deceleration request
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[LEVEL_MSB:LEVEL_LSB] == LVL_NONE)
      |-> (m_axis_tdata[DECEL_W-1:0] == '0))
    else $error("deceleration requested without brake level");

  // an open sink lets the whole pipeline move
  a_ready_flow: assert property (@(posedge clk_i)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind ttc_emergency_brake_decision_top ebd_checker u_ebd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/ttc_emergency_brake_decision_top_tb.sv -----
// Self-checking testbench of the time-to-collision emergency brake decision block.
`timescale 1ns / 100ps

module ttc_emergency_brake_decision_top_tb;
  import ebd_pkg::*;

  localparam int POS_W = POS_WIDTH_DEF;
  localparam int VEL_W = VEL_WIDTH_DEF;
  localparam int IN_W = ((3 * POS_W + 3 * VEL_W + 7) / 8) * 8;
  localparam int PIPE_LAT = ((POS_W > VEL_W) ? POS_W : VEL_W) + 6;
  localparam int PARK_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_PHASES = 7;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
  } target_t;

  typedef struct {
    logic signed [DECEL_W-1:0] decel;
    brake_level_e              level;
  } brake_cmd_t;

  class brake_scoreboard;
    ebd_cfg_t   regs;
    brake_cmd_t pending_cmds[$];
    int         mismatches;

    function new();
      regs = CFG_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_OFFSET:     regs.offset = val;
        CFG_FB_TTC:     regs.fb_ttc = val;
        CFG_PB_TTC:     regs.pb_ttc = val;
        CFG_HALF_WIDTH: regs.half_width = val;
        CFG_FB_DECEL:   regs.fb_decel = val;
        CFG_PB_DECEL:   regs.pb_decel = val;
        default: ;
      endcase
    endfunction

    // digit-by-digit floor square root
    function longint floor_root(longint n);
      longint root;
      longint bitv;
      root = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function brake_cmd_t decide_brake(target_t t);
      brake_cmd_t cmd;
      longint ax, ay, az, bx, by, bz;
      longint range_mm, speed, dist_mm, lhs;
      bit on_path, full, pre;
      cmd.decel = '0;
      cmd.level = LVL_NONE;
      if (t.vx < 0) begin
        ax = mag(t.px);
        ay = mag(t.py);
        az = mag(t.pz);
        bx = mag(t.vx);
        by = mag(t.vy);
        bz = mag(t.vz);
        range_mm = floor_root(ax * ax + ay * ay + az * az);
        speed = floor_root(bx * bx + by * by + bz * bz);
        dist_mm = range_mm - longint'(regs.offset);
        lhs = dist_mm * 1000;
        on_path = ay < longint'(regs.half_width);
        full = lhs < longint'(regs.fb_ttc) * speed;
        pre = lhs < longint'(regs.pb_ttc) * speed;
        if (full && on_path) begin
          cmd.decel = regs.fb_decel;
          cmd.level = LVL_FULL;
        end else if (pre && on_path) begin
          cmd.decel = regs.pb_decel;
          cmd.level = LVL_PRE;
        end
      end
      return cmd;
    endfunction

    function void note_target(target_t t);
      pending_cmds.push_back(decide_brake(t));
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] w);
      brake_cmd_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        $error("output word 0x%h with no target pending", w);
        mismatches++;
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (w[DECEL_W-1:0] !== exp_cmd.decel) begin
        $error("decel_request: expected %0d, actual %0d",
               exp_cmd.decel, $signed(w[DECEL_W-1:0]));
        mismatches++;
      end
      if (w[LEVEL_MSB:LEVEL_LSB] !== exp_cmd.level) begin
        $error("brake_level: expected %0d, actual %0d",
               exp_cmd.level, w[LEVEL_MSB:LEVEL_LSB]);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_W-1:0]         s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;

  brake_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  park_req = 1'b0;
  int  quiet_cycles = 0;

  ttc_emergency_brake_decision_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic target_t mk(int px, int py, int pz, int vx, int vy, int vz);
    target_t t;
    t.px = px[POS_W-1:0];
    t.py = py[POS_W-1:0];
    t.pz = pz[POS_W-1:0];
    t.vx = vx[VEL_W-1:0];
    t.vy = vy[VEL_W-1:0];
    t.vz = vz[VEL_W-1:0];
    return t;
  endfunction

  function automatic int flip(int v);
    return ($urandom_range(1) == 1) ? -v : v;
  endfunction

  function automatic target_t random_target();
    target_t t;
    int kind, spd, ttc, rng, lat;
    kind = $urandom_range(99);
    if (kind < 20) begin
      // raw noise over the full field ranges
      t.px = POS_W'($urandom);
      t.py = POS_W'($urandom);
      t.pz = POS_W'($urandom);
      t.vx = VEL_W'($urandom);
      t.vy = VEL_W'($urandom);
      t.vz = VEL_W'($urandom);
    end else begin
      spd = $urandom_range(1, 40000);
      ttc = $urandom_range(0, 3000);
      rng = spd * ttc / 1000 + int'(sb.regs.offset);
      if (rng > 524287) rng = 524287;
      lat = $urandom_range(0, int'(sb.regs.half_width) + int'(sb.regs.half_width) / 4 + 2);
      if ($urandom_range(19) == 0) lat = int'(sb.regs.half_width);
      // opening targets mixed in with the closing ones
      t = mk(rng, flip(lat), flip($urandom_range(0, 500)),
             (kind < 30) ? int'($urandom_range(0, 40000)) : -spd,
             flip($urandom_range(0, spd / 4)), flip($urandom_range(0, spd / 8)));
    end
    return t;
  endfunction

  task automatic send_target(target_t t);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({t.vz, t.vy, t.vx, t.pz, t.py, t.px});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    // one edge first so the monitor has noted the last accepted word
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  task automatic program_phase(int p);
    case (p)
      1: begin
        // range offset above any short target, zero time limits
        poke_reg(CFG_OFFSET, 16'hFFFF);
        poke_reg(CFG_FB_TTC, 16'd0);
        poke_reg(CFG_PB_TTC, 16'd0);
        poke_reg(CFG_HALF_WIDTH, 16'hFFFF);
        poke_reg(CFG_FB_DECEL, 16'h8000);
        poke_reg(CFG_PB_DECEL, 16'h7FFF);
      end
      2: begin
        poke_reg(CFG_OFFSET, 16'd0);
        poke_reg(CFG_FB_TTC, 16'hFFFF);
        poke_reg(CFG_PB_TTC, 16'hFFFF);
        poke_reg(CFG_FB_DECEL, 16'h7FFF);
        poke_reg(CFG_PB_DECEL, 16'hFFFF);
      end
      NUM_PHASES - 1: begin
        poke_reg(CFG_OFFSET, 16'd0);
        poke_reg(CFG_FB_TTC, 16'd0);
        poke_reg(CFG_PB_TTC, 16'd0);
        poke_reg(CFG_HALF_WIDTH, 16'd0);
        poke_reg(CFG_FB_DECEL, 16'd0);
        poke_reg(CFG_PB_DECEL, 16'd0);
        // unused indexes must not disturb anything
        poke_reg(CFG_IDX_W'(CFG_PB_DECEL) + 3'd1, 16'h1234);
        poke_reg(CFG_IDX_W'(CFG_PB_DECEL) + 3'd2, 16'hFFFF);
      end
      default: begin
        poke_reg(CFG_OFFSET, ($urandom_range(7) == 0) ? CFG_W'($urandom)
                                                       : CFG_W'($urandom_range(0, 2000)));
        poke_reg(CFG_FB_TTC, CFG_W'($urandom_range(0, 3000)));
        poke_reg(CFG_PB_TTC, CFG_W'($urandom_range(0, 4000)));
        poke_reg(CFG_HALF_WIDTH, CFG_W'($urandom_range(0, 4000)));
        poke_reg(CFG_FB_DECEL, CFG_W'($urandom));
        poke_reg(CFG_PB_DECEL, CFG_W'($urandom));
      end
    endcase
  endtask

  // stimulus
  initial begin
    int idle_tab[NUM_PHASES];
    int stall_tab[NUM_PHASES];
    int count_tab[NUM_PHASES];
    idle_tab  = '{0, 64, 0, 9, 9, 0, 9};
    stall_tab = '{0, 0, 64, 9, 9, 0, 9};
    count_tab = '{150, 120, 120, 150, 150, 120, 40};
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_OFFSET;
    cfg_wdata_i   <= '0;
    wait (rst_ni);
    @(posedge clk_i);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        program_phase(p);
      end
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 5) park_req = 1'b1;
      if (p == 0) begin
        send_target(mk(524287, 0, 0, 131071, 0, 0));
        send_target(mk(0, 0, 0, 0, 0, 0));
        send_target(mk(0, 0, 0, -1, 0, 0));
        send_target(mk(-524288, -524288, -524288, -131072, -131072, -131072));
        send_target(mk(524287, 0, 524287, -131072, 131071, 131071));
        send_target(mk(0, 0, 0, -131072, -131072, -131072));
        // time to collision just under, at and over each limit
        send_target(mk(999, 0, 0, -1000, 0, 0));
        send_target(mk(1000, 0, 0, -1000, 0, 0));
        send_target(mk(1999, 0, 0, -1000, 0, 0));
        send_target(mk(2000, 0, 0, -1000, 0, 0));
        send_target(mk(-999, 0, 0, -1000, 0, 0));
        // lateral offset inside the half width and at it on both sides
        send_target(mk(500, -1499, 0, -1000, 0, 0));
        send_target(mk(500, 1500, 0, -1000, 0, 0));
        send_target(mk(500, -1500, 0, -1000, 0, 0));
        send_target(mk(300, 400, 0, -3, -4, 0));
        send_target(mk(1000, 0, 0, -1, 0, 0));
      end
      if (p == 1) begin
        // zero limits: only a negative distance brakes
        send_target(mk(65535, 0, 0, -1, 0, 0));
        send_target(mk(65534, 0, 0, -1, 0, 0));
        send_target(mk(0, 0, 0, 131071, 0, 0));
      end
      repeat (count_tab[p]) send_target(random_target());
      s_axis_tvalid <= 1'b0;
    end
    settle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (park_req) begin
        park_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < PARK_CYCLES; n++) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    target_t t;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        t.px = s_axis_tdata[POS_W-1:0];
        t.py = s_axis_tdata[2*POS_W-1:POS_W];
        t.pz = s_axis_tdata[3*POS_W-1:2*POS_W];
        t.vx = s_axis_tdata[3*POS_W+VEL_W-1:3*POS_W];
        t.vy = s_axis_tdata[3*POS_W+2*VEL_W-1:3*POS_W+VEL_W];
        t.vz = s_axis_tdata[3*POS_W+3*VEL_W-1:3*POS_W+2*VEL_W];
        sb.note_target(t);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/ebd_pkg.sv
hw/rtl/ebd_square.sv
hw/rtl/ebd_isqrt.sv
hw/rtl/ebd_decide.sv
hw/rtl/ttc_emergency_brake_decision_top.sv
hw/rtl/ebd_checker.sv
verif/ttc_emergency_brake_decision_top_tb.sv
